// ===== design/fht_pkg.sv =====
// Package for the first-fit hole table: command codes, table entry type,
// sequencer states and the request and response structs.
// Used by fht_core, first_fit_hole_table and the testbench; depends on nothing else.
package fht_pkg;

    localparam int FHT_MAX_REGIONS_DEFAULT = 8;
    localparam logic [4:0] PAGE_LOG2_RESET = 5'd12;

    localparam logic [1:0] CMD_FREE  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] len;
    } entry_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] addr;
        logic [31:0] len;
    } req_t;

    typedef struct packed {
        logic        alloc_ok;
        logic [31:0] alloc_address;
        logic [31:0] alloc_length;
        logic [3:0]  region_count;
        logic        table_full;
    } rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_F_END,
        ST_F_SCAN_RD,
        ST_F_SCAN_CMP,
        ST_F_PREV,
        ST_F_DEC,
        ST_F_MERGE3,
        ST_UP_RD,
        ST_UP_WR,
        ST_RM_RD,
        ST_RM_WR,
        ST_A_ROUND,
        ST_A_RD,
        ST_A_CMP,
        ST_A_SUB,
        ST_A_ADD,
        ST_DONE
    } state_t;

endpackage

// ===== design/fht_core.sv =====
// Sequencer, region table memory and shared 32-bit adder of the hole table.
// Depends on fht_pkg.
module fht_core
    import fht_pkg::*;
#(
    parameter int MAX_REGIONS = FHT_MAX_REGIONS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       start,
    input  req_t       req,
    input  logic [4:0] page_log2,
    output logic       idle,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output rsp_t       rsp
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);

    // Region table: one write port, one registered read port.
    entry_t             mem [MAX_REGIONS];
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    entry_t             wr_data;
    logic [IDX_W-1:0]   rd_idx;
    entry_t             rd_q;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rd_q <= mem[rd_idx];
    end

    // Shared adder; subtraction uses the inverted operand and carry in.
    logic [31:0] alu_a, alu_b, alu_sum;
    logic        alu_cin;
    assign alu_sum = alu_a + alu_b + {31'd0, alu_cin};

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic [31:0]        addr_reg, addr_next;
    logic [31:0]        len_reg, len_next;
    logic [31:0]        end_reg, end_next;
    logic [31:0]        acc_reg, acc_next;
    logic [31:0]        rounded_reg, rounded_next;
    entry_t             prev_reg, prev_next;
    entry_t             nxt_reg, nxt_next;
    logic               has_next_reg, has_next_next;
    logic               touch_reg, touch_next;
    logic               ok_reg, ok_next;
    logic [31:0]        gaddr_reg, gaddr_next;
    logic [31:0]        glen_reg, glen_next;
    logic               full_reg, full_next;

    logic [CNT_W-1:0]   idx_m1, j_p1, j_m1;
    logic               next_touch;
    logic [31:0]        page, page_mask, count_wide;

    assign idx_m1     = idx_reg - 1'b1;
    assign j_p1       = j_reg + 1'b1;
    assign j_m1       = j_reg - 1'b1;
    assign next_touch = has_next_reg && (end_reg == nxt_reg.base);
    assign page       = 32'd1 << page_log2;
    assign page_mask  = 32'hFFFF_FFFF << page_log2;
    assign count_wide = 32'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        j_reg        <= j_next;
        cmd_reg      <= cmd_next;
        addr_reg     <= addr_next;
        len_reg      <= len_next;
        end_reg      <= end_next;
        acc_reg      <= acc_next;
        rounded_reg  <= rounded_next;
        prev_reg     <= prev_next;
        nxt_reg      <= nxt_next;
        has_next_reg <= has_next_next;
        touch_reg    <= touch_next;
        ok_reg       <= ok_next;
        gaddr_reg    <= gaddr_next;
        glen_reg     <= glen_next;
        full_reg     <= full_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        j_next        = j_reg;
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        len_next      = len_reg;
        end_next      = end_reg;
        acc_next      = acc_reg;
        rounded_next  = rounded_reg;
        prev_next     = prev_reg;
        nxt_next      = nxt_reg;
        has_next_next = has_next_reg;
        touch_next    = touch_reg;
        ok_next       = ok_reg;
        gaddr_next    = gaddr_reg;
        glen_next     = glen_reg;
        full_next     = full_reg;
        wr_en         = 1'b0;
        wr_idx        = j_reg[IDX_W-1:0];
        wr_data       = rd_q;
        rd_idx        = j_reg[IDX_W-1:0];
        alu_a         = prev_reg.base;
        alu_b         = prev_reg.len;
        alu_cin       = 1'b0;
        rsp_valid     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cmd_next      = req.cmd;
                    addr_next     = req.addr;
                    len_next      = req.len;
                    idx_next      = '0;
                    j_next        = '0;
                    has_next_next = 1'b0;
                    ok_next       = 1'b0;
                    gaddr_next    = '0;
                    glen_next     = '0;
                    full_next     = 1'b0;
                    case (req.cmd)
                        CMD_FREE:  state_next = ST_F_END;
                        CMD_ALLOC: state_next = ST_A_ROUND;
                        CMD_CLEAR: begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        default:   state_next = ST_DONE;
                    endcase
                end
            end

            ST_F_END: begin
                alu_a      = addr_reg;
                alu_b      = len_reg;
                end_next   = alu_sum;
                state_next = ST_F_SCAN_RD;
            end

            // Find the first entry whose base lies above the freed address,
            // keeping the entry just before it and the entry itself.
            ST_F_SCAN_RD: begin
                rd_idx = idx_reg[IDX_W-1:0];
                if (idx_reg == count_reg) begin
                    state_next = ST_F_PREV;
                end else begin
                    state_next = ST_F_SCAN_CMP;
                end
            end

            ST_F_SCAN_CMP: begin
                if (rd_q.base <= addr_reg) begin
                    prev_next  = rd_q;
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_F_SCAN_RD;
                end else begin
                    nxt_next      = rd_q;
                    has_next_next = 1'b1;
                    state_next    = ST_F_PREV;
                end
            end

            ST_F_PREV: begin
                alu_a      = prev_reg.base;
                alu_b      = prev_reg.len;
                touch_next = (idx_reg != '0) && (alu_sum == addr_reg);
                state_next = ST_F_DEC;
            end

            ST_F_DEC: begin
                if (touch_reg) begin
                    alu_a = prev_reg.len;
                    alu_b = len_reg;
                    if (next_touch) begin
                        acc_next   = alu_sum;
                        state_next = ST_F_MERGE3;
                    end else begin
                        wr_en      = 1'b1;
                        wr_idx     = idx_m1[IDX_W-1:0];
                        wr_data    = '{base: prev_reg.base, len: alu_sum};
                        state_next = ST_DONE;
                    end
                end else if (next_touch) begin
                    alu_a      = nxt_reg.len;
                    alu_b      = len_reg;
                    wr_en      = 1'b1;
                    wr_idx     = idx_reg[IDX_W-1:0];
                    wr_data    = '{base: addr_reg, len: alu_sum};
                    state_next = ST_DONE;
                end else if (count_reg == CNT_W'(MAX_REGIONS)) begin
                    full_next  = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    j_next     = count_reg;
                    state_next = ST_UP_RD;
                end
            end

            ST_F_MERGE3: begin
                alu_a      = acc_reg;
                alu_b      = nxt_reg.len;
                wr_en      = 1'b1;
                wr_idx     = idx_m1[IDX_W-1:0];
                wr_data    = '{base: prev_reg.base, len: alu_sum};
                j_next     = idx_reg;
                state_next = ST_RM_RD;
            end

            // Open a slot at the insertion point, moving entries up one by one.
            ST_UP_RD: begin
                rd_idx = j_m1[IDX_W-1:0];
                if (j_reg == idx_reg) begin
                    wr_en      = 1'b1;
                    wr_idx     = idx_reg[IDX_W-1:0];
                    wr_data    = '{base: addr_reg, len: len_reg};
                    count_next = count_reg + 1'b1;
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_UP_WR;
                end
            end

            ST_UP_WR: begin
                wr_en      = 1'b1;
                wr_idx     = j_reg[IDX_W-1:0];
                wr_data    = rd_q;
                j_next     = j_m1;
                state_next = ST_UP_RD;
            end

            // Remove entry j by moving the entries above it down one by one.
            ST_RM_RD: begin
                rd_idx = j_p1[IDX_W-1:0];
                if (j_p1 < count_reg) begin
                    state_next = ST_RM_WR;
                end else begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_DONE;
                end
            end

            ST_RM_WR: begin
                wr_en      = 1'b1;
                wr_idx     = j_reg[IDX_W-1:0];
                wr_data    = rd_q;
                j_next     = j_p1;
                state_next = ST_RM_RD;
            end

            ST_A_ROUND: begin
                alu_a        = len_reg;
                alu_b        = page;
                rounded_next = alu_sum & page_mask;
                state_next   = ST_A_RD;
            end

            ST_A_RD: begin
                rd_idx = j_reg[IDX_W-1:0];
                if (j_reg == count_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_A_CMP;
                end
            end

            ST_A_CMP: begin
                if (rd_q.len >= len_reg) begin
                    ok_next    = 1'b1;
                    gaddr_next = rd_q.base;
                    prev_next  = rd_q;
                    if (rd_q.len > rounded_reg) begin
                        glen_next  = rounded_reg;
                        state_next = ST_A_SUB;
                    end else begin
                        glen_next  = rd_q.len;
                        state_next = ST_RM_RD;
                    end
                end else begin
                    j_next     = j_p1;
                    state_next = ST_A_RD;
                end
            end

            ST_A_SUB: begin
                alu_a      = prev_reg.len;
                alu_b      = ~rounded_reg;
                alu_cin    = 1'b1;
                acc_next   = alu_sum;
                state_next = ST_A_ADD;
            end

            ST_A_ADD: begin
                alu_a      = prev_reg.base;
                alu_b      = rounded_reg;
                wr_en      = 1'b1;
                wr_idx     = j_reg[IDX_W-1:0];
                wr_data    = '{base: alu_sum, len: acc_reg};
                state_next = ST_DONE;
            end

            ST_DONE: begin
                rsp_valid = 1'b1;
                if (rsp_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

    assign rsp = '{
        alloc_ok:      ok_reg,
        alloc_address: gaddr_reg,
        alloc_length:  glen_reg,
        region_count:  count_wide[3:0],
        table_full:    full_reg
    };

    // A dropped free can only happen with every slot in use.
    a_full_means_full_table: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid && rsp.table_full |-> count_reg == CNT_W'(MAX_REGIONS))
        else $error("table_full reported with free slots left");

    a_ok_only_on_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid && rsp.alloc_ok |-> cmd_reg == CMD_ALLOC)
        else $error("alloc_ok reported for a command other than allocate");

    a_count_holds_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        idle && !start |=> $stable(count_reg))
        else $error("region count changed with no command in progress");

    a_done_holds_until_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed before it was taken");

endmodule

// ===== design/first_fit_hole_table.sv =====
// First-fit hole table; reset empties the table and sets page_log2 to 12. Each entry scanned or
// moved takes a read on the single read port, then a compare or a write. With m_tready high,
// m_tvalid rises together with s_tready, so a new transaction is accepted only once the last
// result is registered. Clear and unused commands go straight to the response; a free adds the
// end address, scans, checks the neighbours, then merges, inserts (moving entries up) or joins
// three (moving entries down); an allocate rounds the length, scans, then splits or removes the entry.
module first_fit_hole_table
    import fht_pkg::*;
#(
    parameter int MAX_REGIONS = FHT_MAX_REGIONS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,   // page_log2
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,       // region_address[31:0], length[63:32]
    input  logic [1:0]  s_tuser,       // command[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,       // alloc_address[31:0], alloc_length[63:32],
                                       // region_count[67:64], zero[71:68]
    output logic [1:0]  m_tuser        // alloc_ok[0], table_full[1]
);

    logic [4:0] page_log2_reg;
    logic       out_valid_reg, out_valid_next;
    rsp_t       out_reg, out_next;

    logic       core_idle, core_start, rsp_valid, rsp_ready;
    req_t       core_req;
    rsp_t       core_rsp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_log2_reg <= PAGE_LOG2_RESET;
        end else if (cfg_wr_en) begin
            page_log2_reg <= cfg_wr_data;
        end
    end

    assign s_tready   = core_idle;
    assign core_start = s_tvalid && s_tready;
    assign core_req   = '{cmd: s_tuser, addr: s_tdata[31:0], len: s_tdata[63:32]};

    fht_core #(
        .MAX_REGIONS(MAX_REGIONS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (core_start),
        .req       (core_req),
        .page_log2 (page_log2_reg),
        .idle      (core_idle),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (core_rsp)
    );

    // The result register takes a new result whenever it is empty or being drained.
    assign rsp_ready = !out_valid_reg || m_tready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (rsp_valid && rsp_ready) begin
            out_valid_next = 1'b1;
            out_next       = core_rsp;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.region_count, out_reg.alloc_length,
                       out_reg.alloc_address};
    assign m_tuser  = {out_reg.table_full, out_reg.alloc_ok};

endmodule

// ===== tb/tb_first_fit_hole_table.sv =====
// Testbench for first_fit_hole_table: directed merge, full-table, first-fit and wrap cases,
// then random free/allocate traffic under several page sizes, checked against a local model.
// Depends on fht_pkg and the first_fit_hole_table RTL only.
`timescale 1ns / 100ps

module tb_first_fit_hole_table;
    import fht_pkg::*;

    localparam int HOLES = FHT_MAX_REGIONS_DEFAULT;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [4:0]  cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;

    // Local copy of the hole table and the page size register.
    logic [31:0] hole_base [HOLES];
    logic [31:0] hole_len  [HOLES];
    int unsigned hole_count = 0;
    logic [4:0]  page_shift = PAGE_LOG2_RESET;

    rsp_t        expected_rsp_q [$];
    rsp_t        want_rsp;
    bit          idle_on = 1'b0;
    int unsigned mismatches = 0;
    int unsigned n_sent = 0;
    int unsigned n_grants = 0;
    int unsigned n_misses = 0;
    int unsigned n_drops = 0;

    first_fit_hole_table #(
        .MAX_REGIONS(HOLES)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic void drop_hole(int unsigned k);
        for (int unsigned i = k; i + 1 < hole_count; i++) begin
            hole_base[i] = hole_base[i + 1];
            hole_len[i]  = hole_len[i + 1];
        end
        if (hole_count > 0) begin
            hole_count--;
        end
    endfunction

    // Returns 1 when the freed region needed a new entry and the table was full.
    function automatic bit free_into_table(logic [31:0] addr, logic [31:0] len);
        logic [31:0] end_addr;
        logic [31:0] prev_end;
        int unsigned below;
        int unsigned p;
        end_addr = addr + len;
        below = 0;
        while (below < hole_count && hole_base[below] <= addr) begin
            below++;
        end
        if (below > 0) begin
            p = below - 1;
            prev_end = hole_base[p] + hole_len[p];
            if (prev_end == addr) begin
                hole_len[p] = hole_len[p] + len;
                if (p + 1 < hole_count && end_addr == hole_base[p + 1]) begin
                    hole_len[p] = hole_len[p] + hole_len[p + 1];
                    drop_hole(p + 1);
                end
                return 1'b0;
            end
        end
        if (below < hole_count && end_addr == hole_base[below]) begin
            hole_base[below] = addr;
            hole_len[below]  = hole_len[below] + len;
            return 1'b0;
        end
        if (hole_count >= HOLES) begin
            return 1'b1;
        end
        for (int unsigned i = hole_count; i > below; i--) begin
            hole_base[i] = hole_base[i - 1];
            hole_len[i]  = hole_len[i - 1];
        end
        hole_base[below] = addr;
        hole_len[below]  = len;
        hole_count++;
        return 1'b0;
    endfunction

    function automatic rsp_t predict_table_step(logic [1:0] cmd, logic [31:0] addr,
                                                logic [31:0] len);
        rsp_t        r;
        logic [31:0] page;
        logic [31:0] rounded;
        r = '0;
        case (cmd)
            CMD_FREE: begin
                r.table_full = free_into_table(addr, len);
            end
            CMD_ALLOC: begin
                page    = 32'd1 << page_shift;
                rounded = (len + page) & ~(page - 32'd1);
                for (int unsigned i = 0; i < hole_count && !r.alloc_ok; i++) begin
                    if (hole_len[i] >= len) begin
                        r.alloc_ok      = 1'b1;
                        r.alloc_address = hole_base[i];
                        if (hole_len[i] > rounded) begin
                            r.alloc_length = rounded;
                            hole_len[i]    = hole_len[i] - rounded;
                            hole_base[i]   = hole_base[i] + rounded;
                        end else begin
                            r.alloc_length = hole_len[i];
                            drop_hole(i);
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                hole_count = 0;
            end
            default: begin
            end
        endcase
        r.region_count = hole_count[3:0];
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    // Called at a rising edge; returns at the edge where the transaction is accepted,
    // leaving tvalid high so back-to-back commands need no second assignment.
    task automatic issue_command(logic [1:0] cmd, logic [31:0] addr, logic [31:0] len);
        rsp_t r;
        if (idle_on && $urandom_range(0, 99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {len, addr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_table_step(cmd, addr, len);
        expected_rsp_q.push_back(r);
        n_sent++;
        if (cmd == CMD_ALLOC) begin
            if (r.alloc_ok) n_grants++;
            else n_misses++;
        end
        if (r.table_full) n_drops++;
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_rsp_q.size() != 0);
    endtask

    task automatic write_page_log2(logic [4:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        page_shift = value;
    endtask

    task automatic test_merge_paths();
        issue_command(CMD_ALLOC, 32'h0, 32'h10);
        issue_command(CMD_FREE, 32'h1000, 32'h0);
        issue_command(CMD_FREE, 32'h3000, 32'h1000);
        issue_command(CMD_FREE, 32'h2000, 32'h1000);
        // Touches the zero-length region below and the merged one above.
        issue_command(CMD_FREE, 32'h1000, 32'h1000);
        issue_command(CMD_ALLOC, 32'h0, 32'h10);
        issue_command(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_command(CMD_CLEAR, 32'h0, 32'h0);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < HOLES; i++) begin
            issue_command(CMD_FREE, 32'h40 * i, 32'h20);
        end
        issue_command(CMD_FREE, 32'h1000, 32'h10);
        // Merges with both neighbors even though the table is full.
        issue_command(CMD_FREE, 32'h20, 32'h20);
    endtask

    task automatic test_first_fit_split();
        write_page_log2(5'd4);
        issue_command(CMD_ALLOC, 32'h0, 32'h20);
        issue_command(CMD_ALLOC, 32'h0, 32'h30);
        issue_command(CMD_ALLOC, 32'h0, 32'h21);
        issue_command(CMD_ALLOC, 32'h0, 32'h0);
    endtask

    task automatic test_wraparound();
        write_page_log2(5'd31);
        issue_command(CMD_CLEAR, 32'h0, 32'h0);
        issue_command(CMD_FREE, 32'hFFFF_F000, 32'h2000);
        issue_command(CMD_FREE, 32'h1000, 32'hFFFF_FFFF);
        issue_command(CMD_ALLOC, 32'h0, 32'hFFFF_FFFF);
        write_page_log2(5'd0);
        issue_command(CMD_ALLOC, 32'h0, 32'hFFFF_FFFF);
        issue_command(CMD_ALLOC, 32'h0, 32'h1FFF);
        issue_command(CMD_FREE, 32'hFFFF_FFFF, 32'h0);
        issue_command(CMD_FREE, 32'h0, 32'hFFFF_FFFF);
    endtask

    // Mostly frees and allocations inside a narrow address window so that regions
    // touch, split and fill the table; the rest is clears and unconstrained noise.
    task automatic test_random_traffic(logic [4:0] shift, int unsigned n, bit idle,
                                       bit hold_mid);
        int unsigned counted;
        int          pick;
        logic [31:0] gran;
        logic [31:0] win;
        logic [31:0] flen;
        logic [1:0]  cmd;
        write_page_log2(shift);
        idle_on = idle;
        gran = 32'd1 << ((shift < 4) ? 4 : ((shift > 14) ? 14 : shift));
        win = $urandom();
        counted = 0;
        while (counted < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                flen = $urandom_range(1, 6) * gran;
                if ($urandom_range(0, 9) == 0) begin
                    flen = flen + $urandom_range(0, gran - 1);
                end
                issue_command(CMD_FREE, win + $urandom_range(0, 31) * gran, flen);
                counted++;
            end else if (pick < 80) begin
                issue_command(CMD_ALLOC, $urandom(), $urandom_range(0, 5 * gran));
                counted++;
            end else if (pick < 83) begin
                issue_command(CMD_CLEAR, $urandom(), $urandom());
                win = $urandom();
                counted++;
            end else if (pick < 88) begin
                issue_command(CMD_UNUSED, $urandom(), $urandom());
                counted++;
            end else begin
                cmd = 2'($urandom_range(0, 3));
                issue_command(cmd, $urandom(), $urandom());
                counted++;
            end
            if (hold_mid && counted == n / 2) begin
                wait_for_results();
                hold_mid = 1'b0;
            end
        end
    endtask

    // Result side stalls in random bursts while idling is enabled.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 99) < 20) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_rsp_q.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none actual tdata %h tuser %h",
                         $time, m_tdata, m_tuser);
            end else begin
                want_rsp = expected_rsp_q.pop_front();
                compare_field("alloc_ok", 32'(want_rsp.alloc_ok), 32'(m_tuser[0]));
                compare_field("table_full", 32'(want_rsp.table_full), 32'(m_tuser[1]));
                compare_field("alloc_address", want_rsp.alloc_address, m_tdata[31:0]);
                compare_field("alloc_length", want_rsp.alloc_length, m_tdata[63:32]);
                compare_field("region_count", 32'(want_rsp.region_count),
                              32'(m_tdata[67:64]));
            end
        end
    end

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 5'd0;
        s_tvalid    <= 1'b0;
        s_tdata     <= 64'd0;
        s_tuser     <= CMD_FREE;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_on = 1'b1;
        test_merge_paths();
        test_full_table();
        test_first_fit_split();
        test_wraparound();
        test_random_traffic(5'd4, 150, 1'b1, 1'b0);
        test_random_traffic(5'd0, 100, 1'b1, 1'b1);
        test_random_traffic(5'd16, 100, 1'b0, 1'b0);
        test_random_traffic(5'd31, 80, 1'b1, 1'b0);
        test_random_traffic(5'($urandom_range(4, 16)), 170, 1'b1, 1'b0);
        test_random_traffic(5'd6, 150, 1'b0, 1'b0);

        wait_for_results();
        repeat (4 * HOLES + 20) @(posedge aclk);
        $display("Ran %0d transactions with page_log2 at 0, 4, 6, 12, 16, 31 and one random.",
                 n_sent);
        $display("Allocations granted %0d, not fitting %0d; frees dropped on a full table %0d.",
                 n_grants, n_misses, n_drops);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
